FILE: sv/lrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_pkg
// Shared types and constants of the line raster frame buffer: command codes,
// coordinate width, default panel size and the controller state type.
// ----------------------------------------------------------------------------
package lrf_pkg;

  localparam int DEF_PANEL_WIDTH  = 128;
  localparam int DEF_PANEL_HEIGHT = 64;

  localparam int COORD_W = 11;
  localparam int BADDR_W = 10;

  localparam logic [1:0] OP_LINE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_STEEP,
    ST_SWAP,
    ST_PREP,
    ST_WALK,
    ST_READ,
    ST_RWAIT,
    ST_CLEAR,
    ST_DONE
  } lrf_state_t;

endpackage

FILE: sv/line_raster_framebuffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_raster_framebuffer
// One-bit-per-pixel frame store in 8-row pages with a Bresenham line engine,
// a store clear and a byte read for the panel flush.
// ----------------------------------------------------------------------------
// One command is worked at a time and each gives one result word (the store
// byte for a read inside the store, zero otherwise). A line passes the setup
// states STEEP, SWAP and PREP, then walks one pixel per cycle along the major
// axis (max(|dx|,|dy|)+1 pixels) and hands off the result from DONE; the store,
// with one write and one read port, does one pixel read-modify-write per cycle,
// with the write of one pixel forwarded to the read of the next when both hit
// the same byte. A read passes READ and RWAIT. A clear writes one byte a cycle
// over all PANEL_WIDTH*ceil(PANEL_HEIGHT/8) bytes. After reset the same pass
// clears the store, and in_tready stays low until it ends. A new command is
// taken while a finished result still waits on the output.
module line_raster_framebuffer
  import lrf_pkg::*;
#(
  parameter int PANEL_WIDTH  = DEF_PANEL_WIDTH,
  parameter int PANEL_HEIGHT = DEF_PANEL_HEIGHT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // start_x[10:0], start_y[21:11], end_x[32:22], end_y[43:33], ink[44],
  // byte_addr[54:45], zero[55]
  input  logic [55:0] in_tdata,
  // op[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // read_value[7:0]
  output logic [7:0]  out_tdata
);

  localparam int PAGE_COUNT  = (PANEL_HEIGHT + 7) / 8;
  localparam int STORE_BYTES = PANEL_WIDTH * PAGE_COUNT;
  localparam int AW          = $clog2(STORE_BYTES);
  localparam int CAW         = ((AW > BADDR_W) ? AW : BADDR_W) + 1;

  localparam logic [AW-1:0]    LAST_A = AW'(STORE_BYTES - 1);
  localparam logic [AW-1:0]    W_A    = AW'(PANEL_WIDTH);
  localparam logic signed [11:0] W_S  = 12'(PANEL_WIDTH);
  localparam logic signed [11:0] H_S  = 12'(PANEL_HEIGHT);

  lrf_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] ax_r, ay_r, bx_r, by_r;
  logic signed [COORD_W-1:0] ax_nxt, ay_nxt, bx_nxt, by_nxt;
  logic                      ink_r, ink_nxt;
  logic [BADDR_W-1:0]        addr_r, addr_nxt;
  logic                      steep_r, steep_nxt;
  logic signed [11:0]        u_r, u_nxt, v_r, v_nxt, uend_r, uend_nxt, vend_r, vend_nxt;
  logic [11:0]               dx_r, dx_nxt, dy_r, dy_nxt;
  logic signed [12:0]        err_r, err_nxt;
  logic                      yneg_r, yneg_nxt;
  logic [AW-1:0]             clr_r, clr_nxt;
  logic [7:0]                result_r, result_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_data_r, out_data_nxt;

  logic                      pix_v_r, pix_v_nxt;
  logic [AW-1:0]             pix_addr_r;
  logic [7:0]                pix_mask_r;
  logic                      fwd_r, fwd_nxt;
  logic [7:0]                fwd_data_r;

  logic [7:0]    mem [STORE_BYTES];
  logic [7:0]    mem_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [7:0]    mem_wd;

  logic                      in_acc;
  logic signed [11:0]        sdx, sdy;
  logic [11:0]               adx, ady;
  logic signed [COORD_W-1:0] p0, q0, p1, q1;
  logic signed [11:0]        sdv;
  logic signed [11:0]        x_c, y_c;
  logic                      on_panel;
  logic [AW-1:0]             pix_addr_c;
  logic [7:0]                mask_c;
  logic signed [12:0]        e1;
  logic [7:0]                rd_byte, pix_wd;
  logic                      addr_ok;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // line setup arithmetic
  always_comb begin
    sdx = {bx_r[COORD_W-1], bx_r} - {ax_r[COORD_W-1], ax_r};
    sdy = {by_r[COORD_W-1], by_r} - {ay_r[COORD_W-1], ay_r};
    adx = sdx[11] ? 12'(-sdx) : 12'(sdx);
    ady = sdy[11] ? 12'(-sdy) : 12'(sdy);
    p0  = steep_r ? ay_r : ax_r;
    q0  = steep_r ? ax_r : ay_r;
    p1  = steep_r ? by_r : bx_r;
    q1  = steep_r ? bx_r : by_r;
    sdv = vend_r - v_r;
  end

  // current pixel of the walk
  always_comb begin
    x_c        = steep_r ? v_r : u_r;
    y_c        = steep_r ? u_r : v_r;
    on_panel   = !x_c[11] && (x_c < W_S) && !y_c[11] && (y_c < H_S);
    pix_addr_c = AW'(x_c) + AW'(y_c[10:3]) * W_A;
    mask_c     = 8'b1 << y_c[2:0];
    e1         = err_r - $signed({1'b0, dy_r});
    addr_ok    = CAW'(addr_r) < CAW'(STORE_BYTES);
  end

  // modify stage, with the previous write forwarded on a same-byte hit
  always_comb begin
    rd_byte = fwd_r ? fwd_data_r : mem_q;
    pix_wd  = ink_r ? (rd_byte | pix_mask_r) : (rd_byte & ~pix_mask_r);
  end

  always_comb begin
    state_nxt     = state_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    ink_nxt       = ink_r;
    addr_nxt      = addr_r;
    steep_nxt     = steep_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    uend_nxt      = uend_r;
    vend_nxt      = vend_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    err_nxt       = err_r;
    yneg_nxt      = yneg_r;
    clr_nxt       = clr_r;
    result_nxt    = result_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    pix_v_nxt     = 1'b0;
    mem_re        = 1'b0;
    mem_ra        = pix_addr_c;

    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        clr_nxt = clr_r + AW'(1);
        if (clr_r == LAST_A) begin
          clr_nxt   = '0;
          state_nxt = (state_r == ST_INIT) ? ST_IDLE : ST_DONE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          ax_nxt     = in_tdata[10:0];
          ay_nxt     = in_tdata[21:11];
          bx_nxt     = in_tdata[32:22];
          by_nxt     = in_tdata[43:33];
          ink_nxt    = in_tdata[44];
          addr_nxt   = in_tdata[54:45];
          result_nxt = '0;
          case (in_tuser)
            OP_LINE:  state_nxt = ST_STEEP;
            OP_READ:  state_nxt = ST_READ;
            OP_CLEAR: state_nxt = ST_CLEAR;
            default:  state_nxt = ST_DONE;
          endcase
        end
      end
      ST_STEEP: begin
        steep_nxt = ady > adx;
        state_nxt = ST_SWAP;
      end
      ST_SWAP: begin
        // walk the major axis upward
        if (p0 > p1) begin
          u_nxt    = {p1[COORD_W-1], p1};
          v_nxt    = {q1[COORD_W-1], q1};
          uend_nxt = {p0[COORD_W-1], p0};
          vend_nxt = {q0[COORD_W-1], q0};
        end else begin
          u_nxt    = {p0[COORD_W-1], p0};
          v_nxt    = {q0[COORD_W-1], q0};
          uend_nxt = {p1[COORD_W-1], p1};
          vend_nxt = {q1[COORD_W-1], q1};
        end
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        dx_nxt    = 12'(uend_r - u_r);
        dy_nxt    = sdv[11] ? 12'(-sdv) : 12'(sdv);
        err_nxt   = $signed({2'b00, dx_nxt[11:1]});
        yneg_nxt  = !(v_r < vend_r);
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (u_r <= uend_r) begin
          pix_v_nxt = on_panel;
          mem_re    = on_panel;
          u_nxt     = u_r + 12'sd1;
          if (e1[12]) begin
            v_nxt   = yneg_r ? (v_r - 12'sd1) : (v_r + 12'sd1);
            err_nxt = e1 + $signed({1'b0, dx_r});
          end else begin
            err_nxt = e1;
          end
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        mem_re    = 1'b1;
        mem_ra    = AW'(addr_r);
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        result_nxt = addr_ok ? mem_q : 8'd0;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we  = pix_v_r || (state_r == ST_INIT) || (state_r == ST_CLEAR);
    mem_wa  = pix_v_r ? pix_addr_r : clr_r;
    mem_wd  = pix_v_r ? pix_wd : 8'd0;
    fwd_nxt = pix_v_nxt && pix_v_r && (pix_addr_r == pix_addr_c);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      pix_v_r     <= 1'b0;
      fwd_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      pix_v_r     <= pix_v_nxt;
      fwd_r       <= fwd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    ink_r      <= ink_nxt;
    addr_r     <= addr_nxt;
    steep_r    <= steep_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    uend_r     <= uend_nxt;
    vend_r     <= vend_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    err_r      <= err_nxt;
    yneg_r     <= yneg_nxt;
    result_r   <= result_nxt;
    out_data_r <= out_data_nxt;
    pix_addr_r <= pix_addr_c;
    pix_mask_r <= mask_c;
    fwd_data_r <= pix_wd;
  end

endmodule

FILE: sv/lrf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrf_checker
// Port-level checks of the line raster frame buffer, bound to the top level.
// ----------------------------------------------------------------------------
module lrf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // reset starts the clearing pass: no command taken, no word shown
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !in_tready && !out_tvalid)
    else $error("in_tready or out_tvalid high right after reset");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("command taken while another is in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result word changed or dropped");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_tvalid) && $past(rst_n) |-> $past(out_tready))
    else $error("result word withdrawn without handshake");

endmodule

bind line_raster_framebuffer lrf_checker u_lrf_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for line_raster_framebuffer. Sends line, read, clear
// and unused-op words with random gaps and output stalls. Keeps a shadow copy
// of the frame store, updated per accepted word, and checks each result word
// in order against it or against the fixed value of a directed row.
// ----------------------------------------------------------------------------
module tb;
  import lrf_pkg::*;

  localparam int PW          = DEF_PANEL_WIDTH;
  localparam int PH          = DEF_PANEL_HEIGHT;
  localparam int STORE_BYTES = PW * ((PH + 7) / 8);
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int N_RANDOM    = 1200;
  // longest line walks 2048 pixels, plus a long output stall; taken several times
  localparam int STALL_LIMIT = 10000;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] ey;
    logic               ink;
    logic [BADDR_W-1:0] addr;
    logic               fixed;
    logic [7:0]         fixed_val;
  } cmd_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  logic [7:0] shadow_fb [0:STORE_BYTES-1];
  logic [7:0] pending_bytes [$];
  cmd_t       directed_rows [$];

  int  errors = 0;
  int  words_checked = 0;
  int  idle_cycles = 0;
  int  n_line = 0, n_read = 0, n_clear = 0, n_unused = 0;
  int  last_x = 0, last_y = 0;
  int  stall_left = 0;
  bit  steady = 1'b0;

  always #5 clk = ~clk;

  line_raster_framebuffer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // ---------------------------------------------------------------- shadow store
  task automatic plot_pixel(input int x, input int y, input logic ink);
    int idx;
    if (x < 0 || x >= PW || y < 0 || y >= PH) return;
    idx = x + (y / 8) * PW;
    if (idx < STORE_BYTES) shadow_fb[idx][y % 8] = ink;
  endtask

  task automatic raster_line(input int ax, input int ay, input int bx, input int by,
                             input logic ink);
    int  t, dx, dy, err, ystep, adx, ady;
    bit  steep;
    adx   = (bx < ax) ? ax - bx : bx - ax;
    ady   = (by < ay) ? ay - by : by - ay;
    steep = ady > adx;
    if (steep) begin
      t = ax; ax = ay; ay = t;
      t = bx; bx = by; by = t;
    end
    if (ax > bx) begin
      t = ax; ax = bx; bx = t;
      t = ay; ay = by; by = t;
    end
    dx    = bx - ax;
    dy    = (by < ay) ? ay - by : by - ay;
    err   = dx / 2;
    ystep = (ay < by) ? 1 : -1;
    while (ax <= bx) begin
      if (steep) plot_pixel(ay, ax, ink);
      else plot_pixel(ax, ay, ink);
      err -= dy;
      if (err < 0) begin
        ay  += ystep;
        err += dx;
      end
      ax++;
    end
  endtask

  task automatic predict_cmd(input cmd_t c, output logic [7:0] value);
    value = 8'h00;
    case (c.op)
      OP_LINE: begin
        raster_line($signed(c.sx), $signed(c.sy), $signed(c.ex), $signed(c.ey), c.ink);
        n_line++;
      end
      OP_READ: begin
        if (c.addr < STORE_BYTES) value = shadow_fb[c.addr];
        n_read++;
      end
      OP_CLEAR: begin
        for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = 8'h00;
        n_clear++;
      end
      default: n_unused++;
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_row(input logic [1:0] op, input int sx, input int sy, input int ex,
                         input int ey, input logic ink, input int addr,
                         input logic fixed, input logic [7:0] fixed_val);
    cmd_t c;
    c.op = op;
    c.sx = sx[COORD_W-1:0];
    c.sy = sy[COORD_W-1:0];
    c.ex = ex[COORD_W-1:0];
    c.ey = ey[COORD_W-1:0];
    c.ink = ink;
    c.addr = addr[BADDR_W-1:0];
    c.fixed = fixed;
    c.fixed_val = fixed_val;
    directed_rows.push_back(c);
  endtask

  function automatic logic [COORD_W-1:0] coord_in(input int lo, input int hi);
    int v;
    v = lo + int'($urandom_range(0, hi - lo));
    return v[COORD_W-1:0];
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int   r, m, cx, cy, ax;
    c = '0;
    r = $urandom_range(0, 99);
    if (r < 52) begin
      c.op  = OP_LINE;
      c.ink = ($urandom_range(0, 9) < 7);
      m = $urandom_range(0, 19);
      if (m == 0) begin
        // full coordinate range, long walks mostly off panel
        c.sx = COORD_W'($urandom); c.sy = COORD_W'($urandom);
        c.ex = COORD_W'($urandom); c.ey = COORD_W'($urandom);
      end else if (m <= 5) begin
        cx = $urandom_range(0, PW - 1);
        cy = $urandom_range(0, PH - 1);
        c.sx = coord_in(cx - 6, cx + 6); c.sy = coord_in(cy - 6, cy + 6);
        c.ex = coord_in(cx - 6, cx + 6); c.ey = coord_in(cy - 6, cy + 6);
      end else begin
        c.sx = coord_in(-16, PW + 15); c.sy = coord_in(-16, PH + 15);
        c.ex = coord_in(-16, PW + 15); c.ey = coord_in(-16, PH + 15);
      end
      last_x = $signed(c.ex);
      last_y = $signed(c.ey);
    end else if (r < 94) begin
      c.op = OP_READ;
      c.sx = COORD_W'($urandom); c.ey = COORD_W'($urandom);
      ax = last_x + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 9) < 6 && ax >= 0 && ax < PW && last_y >= 0 && last_y < PH)
        c.addr = BADDR_W'(ax + (last_y / 8) * PW);
      else
        c.addr = BADDR_W'($urandom);
    end else if (r < 96) begin
      c.op = OP_CLEAR;
    end else begin
      c.op = OP_UNUSED;
      c.sx = COORD_W'($urandom); c.sy = COORD_W'($urandom);
      c.ex = COORD_W'($urandom); c.ey = COORD_W'($urandom);
      c.ink = 1'($urandom); c.addr = BADDR_W'($urandom);
    end
    return c;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_cmd(input cmd_t c);
    logic [7:0] value;
    in_tvalid <= 1'b1;
    in_tuser  <= c.op;
    in_tdata  <= {1'b0, c.addr, c.ink, c.ey, c.ex, c.sy, c.sx};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_cmd(c, value);
    pending_bytes.push_back(c.fixed ? c.fixed_val : value);
    @(negedge clk);
  endtask

  task automatic hold_off(input int gaps);
    if (gaps > 0) begin
      in_tvalid <= 1'b0;
      repeat (gaps) @(negedge clk);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // ---------------------------------------------------------------- receiver
  always @(negedge clk) begin
    if (steady) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 80) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= 1'b0;
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                : $urandom_range(0, 2);
    end
  end

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: result word with none pending, got %02h", $time, out_tdata);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (out_tdata !== want) begin
            $display("%0t: read_value mismatch, expected %02h got %02h",
                     $time, want, out_tdata);
            errors++;
          end
          words_checked++;
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog, no word moved for %0d cycles", $time, idle_cycles);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- main
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_LINE;
    out_tready = 1'b0;
    for (int i = 0; i < STORE_BYTES; i++) shadow_fb[i] = 8'h00;

    add_row(OP_READ,      0,     0,    0,    0, 1'b0,    0, 1'b1, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0, 1023, 1'b1, 8'h00);
    add_row(OP_LINE,      0,     0,  127,    0, 1'b1,    0, 1'b1, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0,    0, 1'b1, 8'h01);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0,  127, 1'b1, 8'h01);
    add_row(OP_LINE,      5,     0,    5,   63, 1'b1,    0, 1'b1, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0, 5+7*PW, 1'b1, 8'hFF);
    add_row(OP_LINE,    100,    40,   10,   20, 1'b1,    0, 1'b1, 8'h00);
    add_row(OP_LINE,     60,    63,   50,    0, 1'b1,    0, 1'b1, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0, 10+2*PW, 1'b0, 8'h00);
    add_row(OP_LINE,  -1024, -1024, 1023, 1023, 1'b1, 1023, 1'b1, 8'h00);
    add_row(OP_LINE,   1023, -1024, -1024, 1023, 1'b0,    0, 1'b1, 8'h00);
    add_row(OP_LINE,    127,    63,  127,   63, 1'b1,    0, 1'b1, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0, 1023, 1'b0, 8'h00);
    add_row(OP_LINE,    -50,   -50,  -10,   -5, 1'b1,    0, 1'b1, 8'h00);
    add_row(OP_LINE,     -1,    -1,   -1,   -1, 1'b1,    0, 1'b1, 8'h00);
    add_row(OP_UNUSED,   -1,    -1,   -1,   -1, 1'b1, 1023, 1'b1, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0, 63+7*PW, 1'b0, 8'h00);
    add_row(OP_CLEAR,     0,     0,    0,    0, 1'b0,    0, 1'b1, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0,    0, 1'b1, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0, 5+7*PW, 1'b1, 8'h00);
    add_row(OP_LINE,      0,    63,  127,    0, 1'b1,    0, 1'b1, 8'h00);
    add_row(OP_LINE,     20,    10,   40,   10, 1'b0,    0, 1'b1, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0, 64+3*PW, 1'b0, 8'h00);
    add_row(OP_READ,      0,     0,    0,    0, 1'b0, 30+PW, 1'b0, 8'h00);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i]);
      hold_off(pick_gap());
    end
    // hold the sender until every result is back
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      steady = ((i / 150) % 4 == 2);
      if (i % 300 == 299) drain_results();
      send_cmd(random_cmd());
      if (!steady) hold_off(pick_gap());
    end
    steady = 1'b0;
    drain_results();
    repeat (20) @(posedge clk);

    $display("covered %0d lines, %0d reads, %0d clears, %0d unused-op words",
             n_line, n_read, n_clear, n_unused);
    $display("%0d result words checked, %0d mismatches", words_checked, errors);
    if (errors == 0 && pending_bytes.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/lrf_pkg.sv
sv/line_raster_framebuffer.sv
sv/lrf_checker.sv
bench/tb.sv
